>>> rtl/core/wpd_pkg.sv
package wpd_pkg;

   localparam int FUNC_W      = 2;
   localparam int SAMPLE_W    = 24;
   localparam int BIN_IDX_W   = 12;
   localparam int CHAN_W      = 4;
   localparam int STATUS_W    = 2;
   localparam int BIN_COUNT_W = 13;
   localparam int WIDTH_W     = 47;
   localparam int FRAME_W     = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int CH_CNT_W    = 5;
   localparam int WIDE_SAMPLE_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_BIN_WIDTH = 2'd1;

   localparam logic [CH_CNT_W-1:0]   CH_CNT_RESET = 5'd1;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 21'd480;
   localparam logic [CSR_DATA_W-1:0] WIDTH_LIMIT  = 21'd1048576;
   localparam logic [WIDTH_W-1:0]    WIDTH_SAT    = '1;
   localparam logic [FRAME_W-1:0]    FRAME_SAT    = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef struct packed {
      func_type                         op;
      logic signed [WIDE_SAMPLE_W-1:0]  sample;
      logic [BIN_IDX_W-1:0]             bin_index;
      logic [CHAN_W-1:0]                channel;
   } req_item_type;

   typedef struct packed {
      status_type                  status;
      logic signed [SAMPLE_W-1:0]  min_value;
      logic signed [SAMPLE_W-1:0]  max_value;
      logic [BIN_COUNT_W-1:0]      bin_count;
      logic [WIDTH_W-1:0]          bin_width;
      logic [FRAME_W-1:0]          frame_total;
      logic                        complete;
   } rsp_item_type;

   typedef struct packed {
      logic                   we;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

endpackage

>>> rtl/core/wpd_req_if.sv
interface wpd_req_if import wpd_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [FUNC_W-1:0]           func;
   logic signed [SAMPLE_W-1:0]  sample;
   logic [BIN_IDX_W-1:0]        bin_index;
   logic [CHAN_W-1:0]           channel;

   modport source (output valid, func, sample, bin_index, channel, input ready);
   modport sink   (input valid, func, sample, bin_index, channel, output ready);
endinterface

>>> rtl/core/wpd_rsp_if.sv
interface wpd_rsp_if import wpd_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic signed [SAMPLE_W-1:0]  min_value;
   logic signed [SAMPLE_W-1:0]  max_value;
   logic [BIN_COUNT_W-1:0]      bin_count;
   logic [WIDTH_W-1:0]          bin_width;
   logic [FRAME_W-1:0]          frame_total;
   logic                        complete;

   modport source (output valid, status, min_value, max_value, bin_count, bin_width,
                   frame_total, complete, input ready);
   modport sink   (input valid, status, min_value, max_value, bin_count, bin_width,
                   frame_total, complete, output ready);
endinterface

>>> rtl/core/wpd_front.sv
module wpd_front import wpd_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   wpd_req_if.sink       req,
   output logic          head_valid,
   output req_item_type  head_item,
   input  logic          head_pop
);

   localparam int QUEUE_DEPTH = 2;
   localparam logic signed [WIDE_SAMPLE_W:0] SAMPLE_HI =
      (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
   localparam logic signed [WIDE_SAMPLE_W:0] SAMPLE_LO = -SAMPLE_HI - 33'sd1;

   req_item_type                   queue_ff [QUEUE_DEPTH];
   logic                           wr_ptr_ff, wr_ptr_in;
   logic                           rd_ptr_ff, rd_ptr_in;
   logic [1:0]                     count_ff, count_in;
   logic                           push;
   logic signed [WIDE_SAMPLE_W:0]  wide_sample;
   logic signed [WIDE_SAMPLE_W:0]  clamped;
   req_item_type                   item;

   // Classify and clamp the request on its way into the queue.
   always_comb begin
      wide_sample = 33'(req.sample);
      if (wide_sample > SAMPLE_HI) begin
         clamped = SAMPLE_HI;
      end else if (wide_sample < SAMPLE_LO) begin
         clamped = SAMPLE_LO;
      end else begin
         clamped = wide_sample;
      end
      item.op        = func_type'(req.func);
      item.sample    = clamped[WIDE_SAMPLE_W-1:0];
      item.bin_index = req.bin_index;
      item.channel   = req.channel;
   end

   assign req.ready  = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> rtl/core/wpd_back.sv
module wpd_back import wpd_pkg::*; #(
   parameter int MAX_BINS     = 4096,
   parameter int MAX_CHANNELS = 16,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  csr_write_type  csr,
   input  logic           head_valid,
   input  req_item_type   head_item,
   output logic           head_pop,
   output logic           rsp_valid,
   output rsp_item_type   rsp_item,
   input  logic           rsp_ready
);

   localparam int BIN_AW    = $clog2(MAX_BINS);
   localparam int CH_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ADDR_W    = BIN_AW + CH_AW;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int BH_W      = $clog2(MAX_BINS + 1);
   localparam int SW        = SAMPLE_BITS;
   localparam logic [BH_W-1:0]     BINS_FULL = BH_W'(MAX_BINS);
   localparam logic [BH_W-1:0]     BINS_HALF = BH_W'(MAX_BINS / 2);
   localparam logic [BIN_AW-1:0]   LAST_PAIR = BIN_AW'(MAX_BINS / 2 - 1);
   localparam logic [CH_CNT_W-1:0] CH_LIMIT  = CH_CNT_W'(MAX_CHANNELS);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_MERGE  = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_LOOKUP = 6'b010000,
      ST_UPDATE = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [CH_CNT_W-1:0]     ch_cnt_ff, ch_cnt_in;
   logic [BH_W-1:0]         bh_ff, bh_in;
   logic [WIDTH_W-1:0]      fpb_ff, fpb_in;
   logic [WIDTH_W-1:0]      fib_ff, fib_in;
   logic [FRAME_W-1:0]      frames_ff, frames_in;
   logic [CH_CNT_W-1:0]     cp_ff, cp_in;
   logic                    finished_ff, finished_in;
   req_item_type            work_ff, work_in;
   logic [BIN_AW-1:0]       mb_ff, mb_in;
   logic [CH_CNT_W-1:0]     mc_ff, mc_in;
   logic                    mpend_ff, mpend_in;
   logic [ADDR_W-1:0]       mdest_ff, mdest_in;
   logic [ADDR_W-1:0]       look_addr_ff, look_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_ff, rsp_in;

   // Each entry holds {maximum, minimum}.
   logic [2*SW-1:0]         mem [MEM_DEPTH];
   logic [2*SW-1:0]         rd0_ff, rd1_ff;
   logic [ADDR_W-1:0]       rd_addr0, rd_addr1;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [2*SW-1:0]         mem_wdata;

   logic                    opens, push_live, read_ok;
   logic [BH_W-1:0]         bh_look;
   logic [31:0]             bin32;
   logic [BIN_AW-1:0]       pair_lo, pair_hi;
   logic signed [SW-1:0]    sample_v;
   logic signed [SW-1:0]    r0_min, r0_max, r1_min, r1_max;
   logic signed [SW-1:0]    new_min, new_max;
   logic signed [31:0]      out_min, out_max;
   logic [CH_CNT_W:0]       cp_next, mc_next;
   logic [WIDTH_W:0]        fib_next;
   logic [CH_CNT_W-1:0]     cfg_ch;
   logic [CSR_DATA_W-1:0]   cfg_width;

   always_comb begin
      sample_v  = work_ff.sample[SW-1:0];
      r0_min    = rd0_ff[SW-1:0];
      r0_max    = rd0_ff[2*SW-1:SW];
      r1_min    = rd1_ff[SW-1:0];
      r1_max    = rd1_ff[2*SW-1:SW];
      opens     = (fib_ff == '0) && (cp_ff == '0);
      push_live = (work_ff.op == FUNC_PUSH) && !finished_ff;
      bin32     = 32'(work_ff.bin_index);
      read_ok   = (bin32 < 32'(bh_ff)) && (CH_CNT_W'(work_ff.channel) < ch_cnt_ff);
      if (!push_live) begin
         bh_look = bh_ff;
      end else if (opens) begin
         bh_look = bh_ff + BH_W'(1);
      end else if (bh_ff == '0) begin
         bh_look = BH_W'(1);
      end else begin
         bh_look = bh_ff;
      end
      pair_lo = mb_ff << 1;
      pair_hi = pair_lo | BIN_AW'(1);
      cp_next  = {1'b0, cp_ff} + (CH_CNT_W + 1)'(1);
      mc_next  = {1'b0, mc_ff} + (CH_CNT_W + 1)'(1);
      fib_next = {1'b0, fib_ff} + (WIDTH_W + 1)'(1);
      new_min  = (fib_ff == '0 || sample_v < r0_min) ? sample_v : r0_min;
      new_max  = (fib_ff == '0 || sample_v > r0_max) ? sample_v : r0_max;
   end

   assign rd_addr0 = (state_ff == ST_MERGE) ? {pair_lo, mc_ff[CH_AW-1:0]} : look_addr_in;
   assign rd_addr1 = {pair_hi, mc_ff[CH_AW-1:0]};

   // Merge writes follow their reads in the next cycle; the sample update owns the
   // port only in the update state, so the two never collide.
   always_comb begin
      if (mpend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = mdest_ff;
         mem_wdata = {((r0_max > r1_max) ? r0_max : r1_max),
                      ((r0_min < r1_min) ? r0_min : r1_min)};
      end else begin
         mem_we    = (state_ff == ST_UPDATE) && push_live;
         mem_waddr = look_addr_ff;
         mem_wdata = {new_max, new_min};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   always_comb begin
      state_in     = state_ff;
      ch_cnt_in    = ch_cnt_ff;
      bh_in        = bh_ff;
      fpb_in       = fpb_ff;
      fib_in       = fib_ff;
      frames_in    = frames_ff;
      cp_in        = cp_ff;
      finished_in  = finished_ff;
      work_in      = work_ff;
      mb_in        = mb_ff;
      mc_in        = mc_ff;
      mpend_in     = 1'b0;
      mdest_in     = mdest_ff;
      look_addr_in = look_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      head_pop     = 1'b0;
      out_min      = '0;
      out_max      = '0;
      cfg_ch       = '0;
      cfg_width    = '0;

      case (state_ff)
         ST_IDLE: begin
            // Only one request is in flight, so a free or draining output
            // register is guaranteed empty when its result arrives.
            if (head_valid && (!rsp_valid_ff || rsp_ready)) begin
               head_pop = 1'b1;
               work_in  = head_item;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (push_live && opens && (bh_ff >= BINS_FULL)) begin
               mb_in    = '0;
               mc_in    = '0;
               state_in = ST_MERGE;
            end else begin
               state_in = ST_LOOKUP;
            end
         end
         ST_MERGE: begin
            mpend_in = 1'b1;
            mdest_in = {mb_ff, mc_ff[CH_AW-1:0]};
            if (mc_next >= {1'b0, ch_cnt_ff}) begin
               mc_in = '0;
               if (mb_ff == LAST_PAIR) begin
                  state_in = ST_DRAIN;
               end else begin
                  mb_in = mb_ff + BIN_AW'(1);
               end
            end else begin
               mc_in = mc_next[CH_CNT_W-1:0];
            end
         end
         ST_DRAIN: begin
            bh_in    = BINS_HALF;
            fpb_in   = (fpb_ff > (WIDTH_SAT >> 1)) ? WIDTH_SAT : (fpb_ff << 1);
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            bh_in = bh_look;
            if (work_ff.op == FUNC_PUSH) begin
               look_addr_in = {BIN_AW'(bh_look - BH_W'(1)), cp_ff[CH_AW-1:0]};
            end else begin
               look_addr_in = {bin32[BIN_AW-1:0], work_ff.channel[CH_AW-1:0]};
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            rsp_in.status = STATUS_OK;
            case (work_ff.op)
               FUNC_PUSH: begin
                  if (finished_ff) begin
                     rsp_in.status = STATUS_REJECTED;
                  end else if (cp_next >= {1'b0, ch_cnt_ff}) begin
                     cp_in = '0;
                     if (frames_ff != FRAME_SAT) begin
                        frames_in = frames_ff + FRAME_W'(1);
                     end
                     fib_in = (fib_next >= {1'b0, fpb_ff}) ? '0 : fib_next[WIDTH_W-1:0];
                  end else begin
                     cp_in = cp_next[CH_CNT_W-1:0];
                  end
               end
               FUNC_READ: begin
                  if (read_ok) begin
                     out_min = 32'(r0_min);
                     out_max = 32'(r0_max);
                  end else begin
                     rsp_in.status = STATUS_RANGE;
                  end
               end
               FUNC_FINISH: begin
                  finished_in = 1'b1;
               end
               default: begin
               end
            endcase
            rsp_in.min_value   = out_min[SAMPLE_W-1:0];
            rsp_in.max_value   = out_max[SAMPLE_W-1:0];
            rsp_in.bin_count   = BIN_COUNT_W'(bh_ff);
            rsp_in.bin_width   = fpb_ff;
            rsp_in.frame_total = frames_in;
            rsp_in.complete    = finished_in;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The user must write configuration only while idle; the block does not enforce it.
      if (csr.we) begin
         case (csr.index)
            REG_CHANNEL_COUNT: begin
               cfg_ch = csr.wdata[CH_CNT_W-1:0];
               if (cfg_ch == '0) begin
                  cfg_ch = CH_CNT_W'(1);
               end else if (cfg_ch > CH_LIMIT) begin
                  cfg_ch = CH_LIMIT;
               end
               ch_cnt_in = cfg_ch;
            end
            REG_INITIAL_BIN_WIDTH: begin
               cfg_width = csr.wdata;
               if (cfg_width == '0) begin
                  cfg_width = CSR_DATA_W'(1);
               end else if (cfg_width > WIDTH_LIMIT) begin
                  cfg_width = WIDTH_LIMIT;
               end
               if (bh_ff == '0) begin
                  fpb_in = WIDTH_W'(cfg_width);
                  fib_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_cnt_ff    <= CH_CNT_RESET;
         bh_ff        <= '0;
         fpb_ff       <= WIDTH_W'(WIDTH_RESET);
         fib_ff       <= '0;
         frames_ff    <= '0;
         cp_ff        <= '0;
         finished_ff  <= 1'b0;
         mpend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_cnt_ff    <= ch_cnt_in;
         bh_ff        <= bh_in;
         fpb_ff       <= fpb_in;
         fib_ff       <= fib_in;
         frames_ff    <= frames_in;
         cp_ff        <= cp_in;
         finished_ff  <= finished_in;
         mpend_ff     <= mpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      mb_ff        <= mb_in;
      mc_ff        <= mc_in;
      mdest_ff     <= mdest_in;
      look_addr_ff <= look_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> rtl/core/waveform_peak_decimator_core.sv
// Min/max peak decimator for interleaved audio.
// Requests enter on req_if (valid/ready): push a sample for the next channel
// of the current frame, read one bin and channel, or finish the recording.
// Every request gives exactly one response on rsp_if with status, extrema of
// a successful read, and the bin count, bin width, frame total and finish
// flag as they stand after that request.
// A two-entry request queue feeds the execution engine, which handles one
// request at a time: a request passes through the decide, lookup and update
// states with a read-modify-write through the single store write port, and
// the engine takes the next request only once the last response is
// registered. A push that opens a bin while the store is full first merges
// bin pairs of every channel, then halves the bin count and doubles the width.
// Reset is synchronous and clears all counters; the store is not cleared.
// csr_we writes register csr_index (0 channel count, 1 initial bin width)
// and may only be used while no request is outstanding. When the response
// side stalls, the result is held in the output register, the queue keeps
// taking requests until full, and only then does req_if.ready drop.
module waveform_peak_decimator_core import wpd_pkg::*; #(
   parameter int MAX_BINS     = 4096,
   parameter int MAX_CHANNELS = 16,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   wpd_req_if.sink                req_if,
   wpd_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic           head_valid;
   req_item_type   head_item;
   logic           head_pop;
   logic           rsp_valid;
   rsp_item_type   rsp_item;
   csr_write_type  csr;

   assign csr = '{we: csr_we, index: csr_index, wdata: csr_wdata};

   wpd_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   wpd_back #(
      .MAX_BINS     (MAX_BINS),
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rsp_ready  (rsp_if.ready)
   );

   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.status      = rsp_item.status;
   assign rsp_if.min_value   = rsp_item.min_value;
   assign rsp_if.max_value   = rsp_item.max_value;
   assign rsp_if.bin_count   = rsp_item.bin_count;
   assign rsp_if.bin_width   = rsp_item.bin_width;
   assign rsp_if.frame_total = rsp_item.frame_total;
   assign rsp_if.complete    = rsp_item.complete;

   a_fail_no_extrema : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status != STATUS_OK) |->
         (rsp_if.min_value == '0) && (rsp_if.max_value == '0))
      else $error("failed request carries extrema");

   a_reject_after_finish : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status == STATUS_REJECTED) |-> rsp_if.complete)
      else $error("push rejected before finish");

   a_width_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.bin_width != '0))
      else $error("bin width reported as zero");

   a_pop_has_head : assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("engine took a request from an empty queue");

endmodule
